### rtl/bdi_pkg.sv
// Shared types, constants and helpers for the backward-difference interpolator.
package bdi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DW         = 48;                     // internal word width
    localparam int CNT_W      = $clog2(MAX_POINTS + 1); // point count width
    localparam int K_W        = $clog2(MAX_POINTS);     // cell index width
    localparam int XW         = 32;                     // io field width

    typedef enum logic [2:0] {
        ST_LOAD_OK = 3'd0,
        ST_EVAL_OK = 3'd1,
        ST_FEW     = 3'd2,
        ST_ZERO_H  = 3'd3,
        ST_SAT     = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD_GO, S_LOAD_RUN, S_DIV_GO, S_DIV_RUN, S_FACTOR, S_MP_RUN,
        S_MD_GO, S_MD_RUN, S_MR_GO, S_MR_RUN, S_ACC, S_FINAL, S_OUT
    } state_t;

    // saturated word plus clamp flag
    typedef struct packed {
        logic                 clmp;
        logic signed [DW-1:0] val;
    } sat_t;

    // data handed from one difference cell to the next
    typedef struct packed {
        logic                 tok;
        logic [CNT_W-1:0]     rem;
        logic signed [DW-1:0] cn;
        logic signed [DW-1:0] co;
        logic                 clmp;
    } bdi_link_t;

    typedef logic [MAX_POINTS-1:0][DW-1:0] rtab_t;

    function automatic sat_t sat_word(input logic signed [DW:0] v);
        sat_t r;
        r.clmp = (v[DW] != v[DW-1]);
        if (!r.clmp) begin
            r.val = v[DW-1:0];
        end else if (v[DW]) begin
            r.val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r.val = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    // round-half-up 2^FRAC_BITS / k!, zero beyond 20!; quotient built bit by bit
    function automatic rtab_t make_rtab();
        rtab_t t;
        logic [63:0] f;
        logic [63:0] one;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] trial;
        one = 64'd1 << FRAC_BITS;
        f   = 64'd1;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (k >= 2) begin
                f = f * 64'(k);
            end
            if (k > 20) begin
                t[k] = '0;
            end else begin
                num = one + (f >> 1);
                q   = '0;
                for (int b = 63; b >= 0; b--) begin
                    trial = q | (64'd1 << b);
                    if (128'(trial) * 128'(f) <= 128'(num)) begin
                        q = trial;
                    end
                end
                t[k] = DW'(q);
            end
        end
        return t;
    endfunction

    localparam rtab_t RECIP = make_rtab();

endpackage

### rtl/bdi_cell.sv
// One backward-difference cell: holds one difference order, updates as the load wave passes.
module bdi_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  bdi_pkg::bdi_link_t   link_in,
    output bdi_pkg::bdi_link_t   link_out,
    output logic signed [bdi_pkg::DW-1:0] value
);
    logic signed [bdi_pkg::DW-1:0] value_reg;
    bdi_pkg::bdi_link_t            link_reg;
    bdi_pkg::sat_t                 diff;
    logic                          en;

    assign en   = link_in.tok && (link_in.rem != '0);
    assign diff = bdi_pkg::sat_word({link_in.cn[bdi_pkg::DW-1], link_in.cn}
                                  - {link_in.co[bdi_pkg::DW-1], link_in.co});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            link_reg  <= '0;
        end else begin
            if (clear) begin
                value_reg <= '0;
            end else if (en) begin
                value_reg <= diff.val;
            end
            link_reg.tok  <= link_in.tok;
            link_reg.rem  <= (link_in.rem != '0) ? link_in.rem - 1'b1 : '0;
            link_reg.cn   <= diff.val;
            link_reg.co   <= value_reg;
            link_reg.clmp <= link_in.clmp | (en & diff.clmp);
        end
    end

    assign value    = value_reg;
    assign link_out = link_reg;
endmodule

### rtl/bdi_mul.sv
// Fixed-point multiplier: 48x48 magnitude product from four 24x24 partial products, then clamp.
module bdi_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [bdi_pkg::DW-1:0] a,
    input  logic signed [bdi_pkg::DW-1:0] b,
    output logic                          done,
    output logic signed [bdi_pkg::DW-1:0] result,
    output logic                          clamp
);
    localparam int H  = bdi_pkg::DW / 2;
    localparam int PW = 2 * bdi_pkg::DW;
    localparam int MW = PW - bdi_pkg::FRAC_BITS;

    logic [bdi_pkg::DW-1:0] ma_reg, mb_reg;
    logic                   neg_reg;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [1:0]             step_reg;
    logic                   run_reg, done_reg;
    logic [H-1:0]           opa, opb;
    logic [2*H-1:0]         pp;
    logic [MW-1:0]          mag;
    logic [bdi_pkg::DW-1:0] lim, magc;

    always_comb begin
        opa = step_reg[1] ? ma_reg[bdi_pkg::DW-1:H] : ma_reg[H-1:0];
        opb = step_reg[0] ? mb_reg[bdi_pkg::DW-1:H] : mb_reg[H-1:0];
        pp  = opa * opb;
        unique case (step_reg)
            2'd0:    prod_next = prod_reg + PW'(pp);
            2'd3:    prod_next = prod_reg + (PW'(pp) << (2 * H));
            default: prod_next = prod_reg + (PW'(pp) << H);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg   <= a[bdi_pkg::DW-1] ? bdi_pkg::DW'(-a) : a;
            mb_reg   <= b[bdi_pkg::DW-1] ? bdi_pkg::DW'(-b) : b;
            neg_reg  <= a[bdi_pkg::DW-1] ^ b[bdi_pkg::DW-1];
            prod_reg <= '0;
        end else if (run_reg) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        mag   = prod_reg[PW-1:bdi_pkg::FRAC_BITS];
        lim   = neg_reg ? {1'b1, {(bdi_pkg::DW-1){1'b0}}} : {1'b0, {(bdi_pkg::DW-1){1'b1}}};
        clamp = mag > MW'(lim);
        magc  = clamp ? lim : mag[bdi_pkg::DW-1:0];
        result = neg_reg ? -magc : magc;
    end

    assign done = done_reg;
endmodule

### rtl/bdi_div.sv
// Restoring divider for u = (dx << FRAC_BITS) / h, one quotient bit per cycle, clamped to 48 bits.
module bdi_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [bdi_pkg::XW:0]   dx,
    input  logic signed [bdi_pkg::XW:0]   h,
    output logic                          done,
    output logic signed [bdi_pkg::DW-1:0] quo,
    output logic                          clamp
);
    localparam int NW  = bdi_pkg::XW + 1 + bdi_pkg::FRAC_BITS;
    localparam int DVW = bdi_pkg::XW + 1;
    localparam int CW  = $clog2(NW + 1);

    logic [NW-1:0]  n_reg, q_reg;
    logic [DVW-1:0] d_reg, rem_reg, dxm, hm;
    logic [DVW:0]   rem_sh;
    logic           ge, neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           run_reg, done_reg;
    logic [bdi_pkg::DW-1:0] lim, qc;

    assign dxm    = dx[bdi_pkg::XW] ? DVW'(-dx) : DVW'(dx);
    assign hm     = h[bdi_pkg::XW] ? DVW'(-h) : DVW'(h);
    assign rem_sh = {rem_reg, n_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= NW'(dxm) << bdi_pkg::FRAC_BITS;
            d_reg   <= hm;
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= dx[bdi_pkg::XW] ^ h[bdi_pkg::XW];
        end else if (run_reg) begin
            rem_reg <= ge ? DVW'(rem_sh - {1'b0, d_reg}) : DVW'(rem_sh);
            n_reg   <= n_reg << 1;
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    always_comb begin
        lim   = neg_reg ? {1'b1, {(bdi_pkg::DW-1){1'b0}}} : {1'b0, {(bdi_pkg::DW-1){1'b1}}};
        clamp = q_reg > NW'(lim);
        qc    = clamp ? lim : q_reg[bdi_pkg::DW-1:0];
        quo   = neg_reg ? -qc : qc;
    end

    assign done = done_reg;
endmodule

### rtl/backward_difference_interpolator.sv
// Top level of the Newton backward-difference interpolator in signed Q16.16.
//
// Input stream (s_*): one word per item. s_tuser = {first_point, op}; s_tdata
// = {y_value, x_value}. op 0 loads an equally spaced point, op 1 evaluates at x.
// Result stream (m_*): one word per item. m_tdata = result_value, m_tuser = status.
//
// Loads run a wave through a row of MAX_POINTS difference cells, one cell per
// cycle; a load's result is queued once the wave leaves the last cell. A full
// table, too few points or zero spacing go straight to the output stage. A query
// runs a bit-serial divider for u, then per difference order three passes
// through the shared four-step multiplier plus an accumulate. One item is
// worked at a time; s_tready is high only while idle, so the next word can be
// taken in the cycle after the previous result enters the output register.
//
// Reset clears the difference cells, the point count and both stored x values,
// and empties the output register. When the receiver stalls, the result waits
// in the output register; the block can still take and work the next item and
// holds its own result until the register frees.
module backward_difference_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] x_value, [63:32] y_value
    input  logic [1:0]  s_tuser,   // [0] op, [1] first_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [2:0]  m_tuser    // [2:0] status
);
    localparam int DW  = bdi_pkg::DW;
    localparam int MP  = bdi_pkg::MAX_POINTS;
    localparam int CW  = bdi_pkg::CNT_W;
    localparam int XW  = bdi_pkg::XW;

    bdi_pkg::state_t state_reg, state_next;

    // stored set
    logic [CW-1:0]          count_reg;
    logic signed [XW-1:0]   newest_reg, prev_reg;
    // item hold
    logic signed [XW-1:0]   x_reg, y_reg;
    // query datapath
    logic signed [DW-1:0]   u_reg, p_reg, term_reg, acc_reg;
    logic [CW-1:0]          k_reg;
    logic                   qclamp_reg;
    // pending result and output register
    logic [XW-1:0]          res_reg;
    bdi_pkg::status_t       stat_reg;
    logic                   m_valid_reg;
    logic [XW-1:0]          m_data_reg;
    logic [2:0]             m_user_reg;

    logic accept, is_eval, first;
    logic clear_cells;

    // cell chain
    bdi_pkg::bdi_link_t     links [MP+1];
    logic signed [DW-1:0]   vals  [MP];

    // shared units
    logic                   mul_start, mul_done, mul_clamp;
    logic signed [DW-1:0]   mul_a, mul_b, mul_res;
    logic                   div_start, div_done, div_clamp;
    logic signed [DW-1:0]   div_q;
    logic signed [XW:0]     div_dx, div_h;

    bdi_pkg::sat_t          factor, acc_sum;
    logic signed [DW-1:0]   cell_k;
    logic signed [DW-1:0]   acc32;
    logic                   acc32_clamp;

    assign accept  = s_tvalid && s_tready;
    assign is_eval = s_tuser[0];
    assign first   = s_tuser[1];
    assign s_tready = (state_reg == bdi_pkg::S_IDLE);
    assign clear_cells = accept && !is_eval && first;

    // load wave enters cell 0 with cn = y, co = 0
    always_comb begin
        links[0].tok  = (state_reg == bdi_pkg::S_LOAD_GO);
        links[0].rem  = count_reg + 1'b1;
        links[0].cn   = DW'(y_reg);
        links[0].co   = '0;
        links[0].clmp = 1'b0;
    end

    for (genvar i = 0; i < MP; i++) begin : g_cell
        bdi_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (clear_cells),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .value    (vals[i])
        );
    end

    bdi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .result  (mul_res),
        .clamp   (mul_clamp)
    );

    bdi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dx      (div_dx),
        .h       (div_h),
        .done    (div_done),
        .quo     (div_q),
        .clamp   (div_clamp)
    );

    assign div_dx = {x_reg[XW-1], x_reg} - {newest_reg[XW-1], newest_reg};
    assign div_h  = {newest_reg[XW-1], newest_reg} - {prev_reg[XW-1], prev_reg};
    assign cell_k = vals[k_reg[bdi_pkg::K_W-1:0]];

    // factor = u + (k - 1), acc + term, both saturated to 48 bits
    assign factor  = bdi_pkg::sat_word({u_reg[DW-1], u_reg}
                     + ((DW+1)'(k_reg - 1'b1) << bdi_pkg::FRAC_BITS));
    assign acc_sum = bdi_pkg::sat_word({acc_reg[DW-1], acc_reg}
                     + {term_reg[DW-1], term_reg});

    always_comb begin
        acc32_clamp = 1'b1;
        if (acc_reg > DW'(signed'(33'sh0_7FFF_FFFF))) begin
            acc32 = DW'(signed'(33'sh0_7FFF_FFFF));
        end else if (acc_reg < DW'(signed'(33'sh1_8000_0000))) begin
            acc32 = DW'(signed'(33'sh1_8000_0000));
        end else begin
            acc32       = acc_reg;
            acc32_clamp = 1'b0;
        end
    end

    // next state and unit controls
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = p_reg;
        mul_b      = factor.val;
        unique case (state_reg)
            bdi_pkg::S_IDLE: begin
                if (accept) begin
                    if (!is_eval) begin
                        if (!first && count_reg == CW'(MP)) begin
                            state_next = bdi_pkg::S_OUT;
                        end else begin
                            state_next = bdi_pkg::S_LOAD_GO;
                        end
                    end else if (count_reg < CW'(2)) begin
                        state_next = bdi_pkg::S_OUT;
                    end else if (newest_reg == prev_reg) begin
                        state_next = bdi_pkg::S_OUT;
                    end else begin
                        state_next = bdi_pkg::S_DIV_GO;
                    end
                end
            end
            bdi_pkg::S_LOAD_GO:  state_next = bdi_pkg::S_LOAD_RUN;
            bdi_pkg::S_LOAD_RUN: begin
                if (links[MP].tok) begin
                    state_next = bdi_pkg::S_OUT;
                end
            end
            bdi_pkg::S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = bdi_pkg::S_DIV_RUN;
            end
            bdi_pkg::S_DIV_RUN: begin
                if (div_done) begin
                    state_next = bdi_pkg::S_FACTOR;
                end
            end
            bdi_pkg::S_FACTOR: begin
                mul_start  = 1'b1;
                state_next = bdi_pkg::S_MP_RUN;
            end
            bdi_pkg::S_MP_RUN: begin
                if (mul_done) begin
                    state_next = bdi_pkg::S_MD_GO;
                end
            end
            bdi_pkg::S_MD_GO: begin
                mul_start  = 1'b1;
                mul_b      = cell_k;
                state_next = bdi_pkg::S_MD_RUN;
            end
            bdi_pkg::S_MD_RUN: begin
                if (mul_done) begin
                    state_next = bdi_pkg::S_MR_GO;
                end
            end
            bdi_pkg::S_MR_GO: begin
                mul_start  = 1'b1;
                mul_a      = term_reg;
                mul_b      = bdi_pkg::RECIP[k_reg[bdi_pkg::K_W-1:0]];
                state_next = bdi_pkg::S_MR_RUN;
            end
            bdi_pkg::S_MR_RUN: begin
                if (mul_done) begin
                    state_next = bdi_pkg::S_ACC;
                end
            end
            bdi_pkg::S_ACC: begin
                if (k_reg + 1'b1 == count_reg) begin
                    state_next = bdi_pkg::S_FINAL;
                end else begin
                    state_next = bdi_pkg::S_FACTOR;
                end
            end
            bdi_pkg::S_FINAL: state_next = bdi_pkg::S_OUT;
            bdi_pkg::S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = bdi_pkg::S_IDLE;
                end
            end
            default: state_next = bdi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bdi_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // stored set and output register (control state)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            newest_reg  <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (clear_cells) begin
                count_reg <= '0;
            end
            if (state_reg == bdi_pkg::S_LOAD_RUN && links[MP].tok) begin
                count_reg  <= count_reg + 1'b1;
                prev_reg   <= newest_reg;
                newest_reg <= x_reg;
            end
            if (state_reg == bdi_pkg::S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= s_tdata[XW-1:0];
            y_reg   <= s_tdata[2*XW-1:XW];
            res_reg <= '0;
            if (!is_eval) begin
                stat_reg <= bdi_pkg::ST_FULL;
            end else if (count_reg < CW'(2)) begin
                stat_reg <= bdi_pkg::ST_FEW;
            end else begin
                stat_reg <= bdi_pkg::ST_ZERO_H;
            end
        end
        unique case (state_reg)
            bdi_pkg::S_LOAD_RUN: begin
                if (links[MP].tok) begin
                    stat_reg <= links[MP].clmp ? bdi_pkg::ST_SAT : bdi_pkg::ST_LOAD_OK;
                end
            end
            bdi_pkg::S_DIV_RUN: begin
                if (div_done) begin
                    u_reg      <= div_q;
                    qclamp_reg <= div_clamp;
                    p_reg      <= DW'(1) << bdi_pkg::FRAC_BITS;
                    acc_reg    <= vals[0];
                    k_reg      <= CW'(1);
                end
            end
            bdi_pkg::S_FACTOR: begin
                qclamp_reg <= qclamp_reg | factor.clmp;
            end
            bdi_pkg::S_MP_RUN: begin
                if (mul_done) begin
                    p_reg      <= mul_res;
                    qclamp_reg <= qclamp_reg | mul_clamp;
                end
            end
            bdi_pkg::S_MD_RUN, bdi_pkg::S_MR_RUN: begin
                if (mul_done) begin
                    term_reg   <= mul_res;
                    qclamp_reg <= qclamp_reg | mul_clamp;
                end
            end
            bdi_pkg::S_ACC: begin
                acc_reg    <= acc_sum.val;
                qclamp_reg <= qclamp_reg | acc_sum.clmp;
                k_reg      <= k_reg + 1'b1;
            end
            bdi_pkg::S_FINAL: begin
                res_reg  <= acc32[XW-1:0];
                stat_reg <= (qclamp_reg || acc32_clamp) ? bdi_pkg::ST_SAT
                                                         : bdi_pkg::ST_EVAL_OK;
            end
            bdi_pkg::S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= res_reg;
                    m_user_reg <= stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
endmodule

### rtl/bdi_checker.sv
// Port-level checker for the interpolator, bound to the top level.
module bdi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bdi_pkg::ST_LOAD_OK || m_tuser == bdi_pkg::ST_FEW ||
                     m_tuser == bdi_pkg::ST_ZERO_H || m_tuser == bdi_pkg::ST_FULL)
        |-> m_tdata == '0)
        else $error("nonzero result with load or error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= bdi_pkg::ST_FULL)
        else $error("status code out of range");
endmodule

bind backward_difference_interpolator bdi_checker u_bdi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/backward_difference_interpolator_tb.sv
// Self-checking bench for the backward-difference interpolator stream block.
`timescale 1ns / 100ps

module backward_difference_interpolator_tb;

    localparam int ITEMS     = 800;
    localparam int LIMIT_CYC = 2_000_000;

    typedef struct packed {
        logic        op;
        logic        first;
        logic [31:0] x;
        logic [31:0] y;
    } point_word_t;

    typedef struct packed {
        logic [31:0]      value;
        bdi_pkg::status_t status;
    } interp_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    backward_difference_interpolator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic signed [63:0] diffs [bdi_pkg::MAX_POINTS];
    int                 npoints;
    logic signed [63:0] x_new, x_old;
    bit                 clip;

    point_word_t  pending_points[$];
    interp_word_t expected_interps[$];
    int           errors = 0;
    int           n_results = 0;
    int           n_eval_ok = 0;
    int           n_sat = 0;
    bit           stim_done = 1'b0;
    int           hold_cycles = 0;
    bit           long_hold_done = 1'b0;
    longint       cycle = 0;

    localparam logic signed [63:0] MAX48 = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48 = -MAX48 - 1;

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
        if (v > MAX48) begin
            clip = 1'b1;
            return MAX48;
        end
        if (v < MIN48) begin
            clip = 1'b1;
            return MIN48;
        end
        return v;
    endfunction

    // magnitude multiply, shift right by FRAC_BITS, clamp to 48 bits
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        bit          neg;
        logic [63:0] ma, mb, lim;
        logic [127:0] prod;
        logic [127:0] sh;
        neg  = (a < 0) != (b < 0);
        ma   = a < 0 ? -a : a;
        mb   = b < 0 ? -b : b;
        prod = ma * mb;
        sh   = prod >> bdi_pkg::FRAC_BITS;
        lim  = neg ? 64'(MAX48) + 1 : 64'(MAX48);
        if (sh > {64'd0, lim}) begin
            clip = 1'b1;
            sh   = {64'd0, lim};
        end
        return neg ? -$signed(sh[63:0]) : $signed(sh[63:0]);
    endfunction

    function automatic logic signed [63:0] inv_factorial(input int k);
        logic [63:0] f;
        f = 1;
        if (k > 20) return 0;
        for (int i = 2; i <= k; i++) f = f * i;
        return $signed(((64'd1 << bdi_pkg::FRAC_BITS) + f / 2) / f);
    endfunction

    function automatic interp_word_t interpolate(input point_word_t w);
        interp_word_t       r;
        logic signed [63:0] xq, yv, prev, old, nxt, h, u, p, acc, fac, term;
        xq = {{32{w.x[31]}}, w.x};
        yv = {{32{w.y[31]}}, w.y};
        clip    = 1'b0;
        r.value = '0;
        if (!w.op) begin
            if (w.first) begin
                foreach (diffs[i]) diffs[i] = 0;
                npoints = 0;
            end
            if (npoints >= bdi_pkg::MAX_POINTS) begin
                r.status = bdi_pkg::ST_FULL;
            end else begin
                prev     = yv;
                old      = diffs[0];
                diffs[0] = yv;
                for (int k = 1; k <= npoints && k < bdi_pkg::MAX_POINTS; k++) begin
                    nxt      = diffs[k];
                    prev     = clamp48(prev - old);
                    diffs[k] = prev;
                    old      = nxt;
                end
                x_old = x_new;
                x_new = xq;
                npoints++;
                r.status = clip ? bdi_pkg::ST_SAT : bdi_pkg::ST_LOAD_OK;
            end
        end else if (npoints < 2) begin
            r.status = bdi_pkg::ST_FEW;
        end else if (x_new == x_old) begin
            r.status = bdi_pkg::ST_ZERO_H;
        end else begin
            h   = x_new - x_old;
            u   = clamp48(((xq - x_new) * (64'sd1 <<< bdi_pkg::FRAC_BITS)) / h);
            p   = 64'sd1 <<< bdi_pkg::FRAC_BITS;
            acc = diffs[0];
            for (int k = 1; k < npoints && k < bdi_pkg::MAX_POINTS; k++) begin
                fac  = clamp48(u + 64'(k - 1) * (64'sd1 <<< bdi_pkg::FRAC_BITS));
                p    = qmul(p, fac);
                term = qmul(p, diffs[k]);
                term = qmul(term, inv_factorial(k));
                acc  = clamp48(acc + term);
            end
            if (acc > 64'sd2147483647) begin
                clip = 1'b1;
                acc  = 64'sd2147483647;
            end
            if (acc < -64'sd2147483648) begin
                clip = 1'b1;
                acc  = -64'sd2147483648;
            end
            r.value  = acc[31:0];
            r.status = clip ? bdi_pkg::ST_SAT : bdi_pkg::ST_EVAL_OK;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    task automatic push(input bit op, input bit first, input logic [31:0] x,
                        input logic [31:0] y);
        point_word_t w;
        w.op = op; w.first = first; w.x = x; w.y = y;
        pending_points.push_back(w);
    endtask

    // Directed items, then random point sets each followed by queries, mixed with occasional random single words.
    initial begin
        int n, h, x0;
        push(1, 0, 32'h0001_0000, 0);                      // query, empty set
        push(0, 1, 32'h0000_0000, 32'h0001_0000);
        push(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);          // one point, too few
        push(0, 0, 32'h0000_0000, 32'h0002_0000);          // same x: zero spacing
        push(1, 0, 32'h0003_0000, 0);
        push(0, 1, 32'h8000_0000, 32'h8000_0000);          // extremes, saturate
        push(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push(0, 0, 32'h8000_0000, 32'h8000_0000);
        push(1, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push(1, 0, 32'h8000_0000, 0);
        push(0, 1, 0, 0);                                  // fill table
        for (int i = 1; i < bdi_pkg::MAX_POINTS; i++)
            push(0, 0, 32'(i << 16), 32'(i * i << 16));
        push(0, 0, 32'h0011_0000, 0);                      // table full
        push(1, 0, 32'h0011_8000, 0);
        push(1, 0, 32'hFFFF_8000, 0);
        while (pending_points.size() < ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                push($urandom_range(0, 1), $urandom_range(0, 1), rand_word(), rand_word());
            end else begin
                n  = $urandom_range(0, 7) == 0 ?
                     $urandom_range(bdi_pkg::MAX_POINTS, bdi_pkg::MAX_POINTS + 2)
                     : $urandom_range(2, 6);
                h  = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4 << 16);
                x0 = $urandom_range(0, 1 << 20);
                for (int i = 0; i < n; i++) begin
                    push(0, i == 0, 32'(x0 + i * h), rand_word());
                end
                repeat ($urandom_range(1, 4)) push(1, $urandom_range(0, 1), rand_word(),
                                                   $urandom);
            end
        end
    end

    function automatic int gap_len();
        return $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) == 0 ?
                                               $urandom_range(10, 60) : $urandom_range(1, 3));
    endfunction

    // Driver: offers queued words with random gaps.
    int send_gap = 0;
    int n_sent = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_interps.push_back(interpolate(pending_points.pop_front()));
                n_sent++;
                send_gap = gap_len();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0 || pending_points.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_tvalid <= 1'b0;
                    if (pending_points.size() == 0 && !(s_tvalid && !s_tready))
                        stim_done <= (n_sent > 0);
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_points[0].y, pending_points[0].x};
                    s_tuser  <= {pending_points[0].first, pending_points[0].op};
                end
            end
        end
    end

    // Receiver hold-off: one long stretch mid run, a few shorter ones at random.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
            end else if (!long_hold_done && n_sent >= 300) begin
                hold_cycles    <= 3000;
                long_hold_done <= 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                hold_cycles <= $urandom_range(10, 60);
            end
        end
    end

    // Monitor: random ready, held low during hold-off, compare fields.
    always @(posedge aclk) begin
        interp_word_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_interps.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word: value %h status %0d",
                                               m_tdata, m_tuser);
                end else begin
                    e = expected_interps.pop_front();
                    if (e.status == bdi_pkg::ST_EVAL_OK) n_eval_ok++;
                    if (e.status == bdi_pkg::ST_SAT) n_sat++;
                    if (m_tdata !== e.value || m_tuser !== e.status) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at word %0d: exp %h/%0d got %h/%0d",
                                     n_results, e.value, e.status, m_tdata, m_tuser);
                    end
                end
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(0, 9) < 7 ? 1'b1 : ($urandom_range(0, 9) != 0);
            end
        end
    end

    initial begin
        npoints = 0;
        x_new   = 0;
        x_old   = 0;
        foreach (diffs[i]) diffs[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && expected_interps.size() == 0) && cycle < LIMIT_CYC) begin
            @(posedge aclk);
            cycle++;
        end
        if (cycle >= LIMIT_CYC) begin
            $display("timeout with %0d words outstanding", expected_interps.size());
            $display("** backward_difference_interpolator: FAILED **");
            $finish;
        end
        repeat (400) @(posedge aclk);
        $display("covered %0d words in, %0d out: %0d good evaluations, %0d saturated",
                 n_sent, n_results, n_eval_ok, n_sat);
        if (errors == 0 && expected_interps.size() == 0) begin
            $display("** backward_difference_interpolator: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** backward_difference_interpolator: FAILED **");
        end
        $finish;
    end

endmodule
